### sv/ssksl_pkg.sv
// Shared types and constants for the stereo soft-knee safety limiter.
`timescale 1ns / 1ps

package ssksl_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PEAK,
        S_DIV_T,
        S_MUL_T2,
        S_MUL_T3,
        S_MUL_LIM,
        S_DIV_G,
        S_MUL_WET,
        S_MUL_MIX,
        S_DONE
    } t_state;

    localparam int FRAC_BITS = 30;
    localparam int MIX_BITS  = 16;
    localparam int GAIN_W    = 23;
    localparam int MIX_W     = 17;
    localparam int QUO_W     = 53;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KNEE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CEIL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP = 2'd2;

    localparam logic [GAIN_W-1:0] KNEE_RESET = 23'd3331725;
    localparam logic [GAIN_W-1:0] CEIL_RESET = 23'd3959420;
    localparam logic [MIX_W-1:0]  STEP_RESET = 17'd297;
    localparam logic [MIX_W-1:0]  MIX_ONE    = 17'd65536;

endpackage

### sv/stereo_soft_knee_safety_limiter_unit.sv
// Linked stereo soft-knee peak limiter with an enable crossfade, bit-serial datapath.
`timescale 1ns / 1ps

// One stereo frame enters per transaction on the s_axis side and one limited frame
// leaves per transaction on the m_axis side. The linked peak (larger magnitude of the
// two channels) passes below the knee, is clamped at the ceiling and follows the cubic
// k + (c-k)(t + t^2 - t^3) in between; both channels are scaled by limited/peak and
// crossfaded with the dry signal by the mix level, which ramps by mix_step per frame
// toward 1.0 when enabled and 0.0 when disabled, or jumps there on snap. All arithmetic
// goes through one shift-add multiplier and one restoring divider that each retire one
// bit per clock. A bypassed frame goes from the accepting state straight to the done
// state and from there to the output register. A frame below the knee or silent takes
// a wet and a mix multiplication for each channel, each max(31, SAMPLE_WIDTH) bits long;
// a clamped frame adds a 53-bit divide, and a frame in the knee adds another 53-bit
// divide and three multiplications. The result waits in an output register, and a new
// frame is taken once the datapath is free even while that result has not yet been
// collected.
module stereo_soft_knee_safety_limiter_unit
    import ssksl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                i_cfg_index,
    input  logic [GAIN_W-1:0]                   i_cfg_data,
    // Input frames.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: left_sample, right_sample, zero padding.
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // Fields from bit 0: enable, snap.
    input  logic [1:0]                          s_axis_tuser,
    // Output frames.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: left_out, right_out, zero padding.
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int DATA_W = ((2*SW+7)/8)*8;
    localparam int MPW    = (SW > 31) ? SW : 31;
    localparam int MCW    = (SW + 24 > QUO_W) ? SW + 24 : QUO_W;
    localparam int PW     = MCW + MPW;
    localparam int DVW    = (SW > GAIN_W) ? SW : GAIN_W;
    localparam int CW     = 6;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_ch, n_ch;
    logic [MIX_W-1:0]  r_mix, n_mix;
    logic [GAIN_W-1:0] r_knee, r_ceil;
    logic [MIX_W-1:0]  r_step;
    logic [SW-1:0]     r_l, n_l, r_r, n_r, r_peak, n_peak, r_lo, n_lo, r_ro, n_ro;
    logic [29:0]       r_t, n_t, r_t2, n_t2;
    logic [QUO_W-1:0]  r_g, n_g;
    logic              r_dneg, n_dneg;
    logic [MCW-1:0]    r_mc, n_mc;
    logic [MPW-1:0]    r_mp, n_mp;
    logic [PW-1:0]     r_acc, n_acc;
    logic [QUO_W-1:0]  r_dd, n_dd, r_q, n_q;
    logic [DVW-1:0]    r_dv, n_dv;
    logic [DVW:0]      r_rem, n_rem;
    logic              r_ovalid, n_ovalid;
    logic [DATA_W-1:0] r_odata, n_odata;

    // Datapath helpers.
    logic [PW-1:0]     acc_next;
    logic [DVW:0]      rem_shift;
    logic              quo_bit;
    logic [SW-1:0]     dry, dry_mag, in_l, in_r, mag_l, mag_r, mix_out;
    logic [MIX_W-1:0]  target, mix0, delta;
    logic              en, sn;
    logic [GAIN_W-1:0] knee_d, knee_e;
    logic [30:0]       poly;
    logic [GAIN_W:0]   lim_sum;
    logic [GAIN_W-1:0] lim;
    logic [PW-1:0]     wet_mag, dry_ext, round_q;

    function automatic logic [SW-1:0] mag_of(input logic [SW-1:0] x);
        return x[SW-1] ? (~x + 1'b1) : x;
    endfunction

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        acc_next  = {r_acc[PW-2:0], 1'b0} + (r_mp[MPW-1] ? PW'(r_mc) : '0);
        rem_shift = {r_rem[DVW-1:0], r_dd[QUO_W-1]};
        quo_bit   = (rem_shift >= {1'b0, r_dv});
        dry       = r_ch ? r_r : r_l;
        dry_mag   = mag_of(dry);
        in_l      = s_axis_tdata[SW-1:0];
        in_r      = s_axis_tdata[2*SW-1:SW];
        mag_l     = mag_of(in_l);
        mag_r     = mag_of(in_r);
        en        = s_axis_tuser[0];
        sn        = s_axis_tuser[1];
        target    = en ? MIX_ONE : '0;
        mix0      = sn ? target : r_mix;
        delta     = (target > mix0) ? (target - mix0) : (mix0 - target);
        knee_d    = r_ceil - r_knee;
        knee_e    = GAIN_W'(r_peak) - r_knee;
        poly      = 31'(r_t) + 31'(r_t2) - 31'(acc_next[FRAC_BITS +: 30]);
        lim_sum   = {1'b0, r_knee} + (GAIN_W+1)'(acc_next[FRAC_BITS +: GAIN_W]);
        lim       = (lim_sum > {1'b0, r_ceil}) ? r_ceil : lim_sum[GAIN_W-1:0];
        wet_mag   = (acc_next + (PW'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
        dry_ext   = PW'(dry_mag);
        round_q   = (acc_next + (PW'(1) << (MIX_BITS-1))) >> MIX_BITS;
        mix_out   = r_dneg ? (dry - round_q[SW-1:0]) : (dry + round_q[SW-1:0]);

        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ch     = r_ch;
        n_mix    = r_mix;
        n_l      = r_l;
        n_r      = r_r;
        n_peak   = r_peak;
        n_lo     = r_lo;
        n_ro     = r_ro;
        n_t      = r_t;
        n_t2     = r_t2;
        n_g      = r_g;
        n_dneg   = r_dneg;
        n_mc     = r_mc;
        n_mp     = r_mp;
        n_acc    = r_acc;
        n_dd     = r_dd;
        n_q      = r_q;
        n_dv     = r_dv;
        n_rem    = r_rem;
        n_ovalid = r_ovalid & ~m_axis_tready;
        n_odata  = r_odata;

        if (r_state == S_MUL_T2 || r_state == S_MUL_T3 || r_state == S_MUL_LIM ||
            r_state == S_MUL_WET || r_state == S_MUL_MIX) begin
            n_acc = acc_next;
            n_mp  = {r_mp[MPW-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
        end
        if (r_state == S_DIV_T || r_state == S_DIV_G) begin
            n_rem = quo_bit ? (rem_shift - {1'b0, r_dv}) : rem_shift;
            n_q   = {r_q[QUO_W-2:0], quo_bit};
            n_dd  = {r_dd[QUO_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_l  = in_l;
                    n_r  = in_r;
                    n_ch = 1'b0;
                    if (!en && mix0 == '0) begin
                        n_mix   = '0;
                        n_lo    = in_l;
                        n_ro    = in_r;
                        n_state = S_DONE;
                    end else begin
                        if (target > mix0) begin
                            n_mix = mix0 + ((delta < r_step) ? delta : r_step);
                        end else begin
                            n_mix = mix0 - ((delta < r_step) ? delta : r_step);
                        end
                        n_peak  = (mag_r > mag_l) ? mag_r : mag_l;
                        n_state = S_PEAK;
                    end
                end
            end
            S_PEAK: begin
                n_acc = '0;
                n_rem = '0;
                n_q   = '0;
                if (r_peak == '0 || DVW'(r_peak) <= DVW'(r_knee)) begin
                    // Silent or below the knee: unity gain.
                    n_g     = QUO_W'(1) << FRAC_BITS;
                    n_mc    = MCW'(QUO_W'(1) << FRAC_BITS);
                    n_mp    = MPW'(dry_mag);
                    n_cnt   = CW'(MPW-1);
                    n_state = S_MUL_WET;
                end else if (DVW'(r_peak) >= DVW'(r_ceil)) begin
                    n_dd    = {r_ceil, 30'b0};
                    n_dv    = DVW'(r_peak);
                    n_cnt   = CW'(QUO_W-1);
                    n_state = S_DIV_G;
                end else begin
                    n_dd    = {knee_e, 30'b0};
                    n_dv    = DVW'(knee_d);
                    n_cnt   = CW'(QUO_W-1);
                    n_state = S_DIV_T;
                end
            end
            S_DIV_T: begin
                if (r_cnt == '0) begin
                    n_t     = n_q[29:0];
                    n_mc    = MCW'(n_q[29:0]);
                    n_mp    = MPW'(n_q[29:0]);
                    n_acc   = '0;
                    n_cnt   = CW'(MPW-1);
                    n_state = S_MUL_T2;
                end
            end
            S_MUL_T2: begin
                if (r_cnt == '0) begin
                    n_t2    = acc_next[FRAC_BITS +: 30];
                    n_mc    = MCW'(acc_next[FRAC_BITS +: 30]);
                    n_mp    = MPW'(r_t);
                    n_acc   = '0;
                    n_cnt   = CW'(MPW-1);
                    n_state = S_MUL_T3;
                end
            end
            S_MUL_T3: begin
                if (r_cnt == '0) begin
                    n_mc    = MCW'(knee_d);
                    n_mp    = MPW'(poly);
                    n_acc   = '0;
                    n_cnt   = CW'(MPW-1);
                    n_state = S_MUL_LIM;
                end
            end
            S_MUL_LIM: begin
                if (r_cnt == '0) begin
                    n_dd    = {lim, 30'b0};
                    n_dv    = DVW'(r_peak);
                    n_rem   = '0;
                    n_q     = '0;
                    n_cnt   = CW'(QUO_W-1);
                    n_state = S_DIV_G;
                end
            end
            S_DIV_G: begin
                if (r_cnt == '0) begin
                    n_g     = n_q;
                    n_mc    = MCW'(n_q);
                    n_mp    = MPW'(dry_mag);
                    n_acc   = '0;
                    n_cnt   = CW'(MPW-1);
                    n_state = S_MUL_WET;
                end
            end
            S_MUL_WET: begin
                if (r_cnt == '0) begin
                    // Wet and dry share a sign, so only magnitudes are compared.
                    if (wet_mag >= dry_ext) begin
                        n_mc   = MCW'(wet_mag - dry_ext);
                        n_dneg = dry[SW-1];
                    end else begin
                        n_mc   = MCW'(dry_ext - wet_mag);
                        n_dneg = ~dry[SW-1];
                    end
                    n_mp    = MPW'(r_mix);
                    n_acc   = '0;
                    n_cnt   = CW'(MPW-1);
                    n_state = S_MUL_MIX;
                end
            end
            S_MUL_MIX: begin
                if (r_cnt == '0) begin
                    if (!r_ch) begin
                        n_lo    = mix_out;
                        n_ch    = 1'b1;
                        n_mc    = MCW'(r_g);
                        n_mp    = MPW'(mag_of(r_r));
                        n_acc   = '0;
                        n_cnt   = CW'(MPW-1);
                        n_state = S_MUL_WET;
                    end else begin
                        n_ro    = mix_out;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_odata  = DATA_W'({r_ro, r_lo});
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ch     <= 1'b0;
            r_mix    <= '0;
            r_ovalid <= 1'b0;
            r_knee   <= KNEE_RESET;
            r_ceil   <= CEIL_RESET;
            r_step   <= STEP_RESET;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ch     <= n_ch;
            r_mix    <= n_mix;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_KNEE) begin
                    r_knee <= i_cfg_data;
                end else if (i_cfg_index == REG_CEIL) begin
                    r_ceil <= i_cfg_data;
                end else if (i_cfg_index == REG_STEP) begin
                    r_step <= i_cfg_data[MIX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_l     <= n_l;
        r_r     <= n_r;
        r_peak  <= n_peak;
        r_lo    <= n_lo;
        r_ro    <= n_ro;
        r_t     <= n_t;
        r_t2    <= n_t2;
        r_g     <= n_g;
        r_dneg  <= n_dneg;
        r_mc    <= n_mc;
        r_mp    <= n_mp;
        r_acc   <= n_acc;
        r_dd    <= n_dd;
        r_q     <= n_q;
        r_dv    <= n_dv;
        r_rem   <= n_rem;
        r_odata <= n_odata;
    end

endmodule

### tb/stereo_soft_knee_safety_limiter_unit_test.sv
// Self-checking testbench for the stereo soft-knee safety limiter unit.
`timescale 1ns / 1ps

// Scoreboard: it keeps its own copy of the limiter state, predicts each accepted frame
// and compares the frames that come out of the block against those predictions in order.
class limiter_scoreboard;
    logic [22:0] knee;
    logic [22:0] ceil_lvl;
    logic [16:0] step;
    logic [16:0] mix;
    logic [47:0] pending[$];
    int          errors;
    int          checked;

    function void reset_state();
        knee     = ssksl_pkg::KNEE_RESET;
        ceil_lvl = ssksl_pkg::CEIL_RESET;
        step     = ssksl_pkg::STEP_RESET;
        mix      = 0;
        errors   = 0;
        checked  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [22:0] val);
        case (idx)
            ssksl_pkg::REG_KNEE: knee = val;
            ssksl_pkg::REG_CEIL: ceil_lvl = val;
            ssksl_pkg::REG_STEP: step = val[16:0];
            default: ;
        endcase
    endfunction

    // Divide by 2^sh, rounding to nearest with ties away from zero.
    function longint round_away(longint num, int sh);
        longint mg;
        longint q;
        mg = (num < 0) ? -num : num;
        q  = (mg + (64'sd1 <<< (sh - 1))) >>> sh;
        return (num < 0) ? -q : q;
    endfunction

    function longint curve_peak(longint pk);
        longint d, e, t, t2, t3, p, lim;
        if (pk <= knee) return pk;
        if (pk >= ceil_lvl) return ceil_lvl;
        d   = ceil_lvl - knee;
        e   = pk - knee;
        t   = (e <<< 30) / d;
        t2  = (t * t) >>> 30;
        t3  = (t2 * t) >>> 30;
        p   = t + t2 - t3;
        lim = knee + ((d * p) >>> 30);
        return (lim > ceil_lvl) ? ceil_lvl : lim;
    endfunction

    function logic [23:0] crossfade(longint dry, longint g);
        longint wet;
        wet = round_away(dry * g, 30);
        return 24'(dry + round_away((wet - dry) * longint'(mix), 16));
    endfunction

    function void note_frame(logic signed [23:0] l, logic signed [23:0] r, bit en, bit sn);
        longint tgt, delta, pk, ml, mr, g;
        tgt = en ? 65536 : 0;
        if (sn) mix = 17'(tgt);
        if (!en && mix == 0) begin
            pending.push_back({r, l});
            return;
        end
        if (tgt > mix) begin
            delta = tgt - mix;
            mix   = 17'(mix + ((delta < step) ? delta : step));
        end else begin
            delta = mix - tgt;
            mix   = 17'(mix - ((delta < step) ? delta : step));
        end
        ml = (l < 0) ? -longint'(l) : longint'(l);
        mr = (r < 0) ? -longint'(r) : longint'(r);
        pk = (mr > ml) ? mr : ml;
        g  = (pk == 0) ? (64'sd1 <<< 30) : ((curve_peak(pk) <<< 30) / pk);
        pending.push_back({crossfade(r, g), crossfade(l, g)});
    endfunction

    task report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    task check_frame(logic [47:0] got);
        logic [47:0] want;
        if (pending.size() == 0) begin
            report_mismatch("unexpected frame", got[23:0], 24'd0);
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got[23:0] !== want[23:0]) report_mismatch("left_out", got[23:0], want[23:0]);
        if (got[47:24] !== want[47:24]) report_mismatch("right_out", got[47:24], want[47:24]);
    endtask
endclass

module stereo_soft_knee_safety_limiter_unit_test;
    import ssksl_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [22:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // From bit 0: left_sample, right_sample.
    logic [1:0]  s_axis_tuser;   // From bit 0: enable, snap.
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // From bit 0: left_out, right_out.

    limiter_scoreboard sb;
    bit  idle_on;        // Random idling is allowed while this is set.
    bit  hold_off;       // The receiver is forced to stall while this is set.
    int  frames_sent;

    stereo_soft_knee_safety_limiter_unit #(.SAMPLE_WIDTH(24)) dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Receiver: takes output frames, stalling in random bursts and during hold-off.
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) sb.check_frame(m_axis_tdata);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (m_axis_tready && idle_on && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 5);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= i_rst_n;
            end
        end
    end

    // Sends one frame; the prediction is made on the edge that accepts it. Valid stays
    // up afterwards so that the next frame can follow on the same edge.
    task automatic send_frame(logic [23:0] l, logic [23:0] r, bit en, bit sn);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r, l};
        s_axis_tuser  <= {sn, en};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_frame(l, r, en, sn);
        frames_sent++;
    endtask

    // Waits for every expected frame plus the block's worst-case latency.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [22:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // A sample drawn mostly near the knee region, sometimes anywhere in range.
    function automatic logic [23:0] rand_sample();
        logic [23:0] mg;
        if ($urandom_range(0, 3) == 0) return 24'($urandom);
        mg = 24'($urandom_range(0, 4300000));
        return ($urandom_range(0, 1)) ? -mg : mg;
    endfunction

    task automatic random_run(int n);
        bit en;
        en = 1'b1;
        repeat (n) begin
            // Enable changes in runs so that the mix ramps in both directions.
            if ($urandom_range(0, 199) == 0) en = ~en;
            send_frame(rand_sample(), rand_sample(), en, $urandom_range(0, 49) == 0);
        end
    endtask

    initial begin
        logic [22:0] knees[4];
        logic [22:0] ceils[4];
        logic [22:0] steps[4];
        sb = new();
        sb.reset_state();
        idle_on = 1'b1;
        hold_off = 1'b0;
        frames_sent = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_KNEE;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings: bypass, silence, extremes, snap both ways.
        send_frame(24'h7FFFFF, 24'h800000, 1'b0, 1'b0);
        send_frame(24'h000000, 24'h000000, 1'b1, 1'b0);
        send_frame(24'h7FFFFF, 24'h000001, 1'b1, 1'b1);
        send_frame(24'h800000, 24'h7FFFFF, 1'b1, 1'b0);
        send_frame(24'd3331725, -24'd3331726, 1'b1, 1'b0);
        send_frame(24'd3600000, 24'd100, 1'b1, 1'b0);
        send_frame(24'd3959420, -24'd3959419, 1'b1, 1'b0);
        send_frame(24'h000000, 24'h000000, 1'b1, 1'b0);
        send_frame(24'h400000, 24'hC00000, 1'b0, 1'b0);
        send_frame(24'h3FFFFF, 24'h123456, 1'b0, 1'b1);
        send_frame(24'h3FFFFF, 24'h123456, 1'b0, 1'b0);
        drain();
        // Knee above ceiling; unused register index; full-scale step.
        write_reg(REG_KNEE, 23'd4194304);
        write_reg(REG_CEIL, 23'd1);
        write_reg(2'd3, 23'h7FFFFF);
        write_reg(REG_STEP, 23'd65536);
        send_frame(24'h7FFFFF, 24'h000002, 1'b1, 1'b0);
        send_frame(24'h400000, 24'hC00001, 1'b1, 1'b0);
        send_frame(24'h000001, 24'h000000, 1'b1, 1'b0);
        send_frame(24'h800000, 24'h000000, 1'b0, 1'b0);
        drain();

        // Random phases over several settings, the extremes among them.
        knees = '{23'd3331725, 23'd0, 23'd1000000, 23'd4194304};
        ceils = '{23'd3959420, 23'd4194304, 23'd1000001, 23'd4194304};
        steps = '{23'd297, 23'd1, 23'd65536, 23'd5000};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_KNEE, knees[ph]);
            write_reg(REG_CEIL, ceils[ph]);
            write_reg(REG_STEP, steps[ph]);
            if (ph == 1) begin
                // Long receiver hold-off while frames keep being offered.
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (1500) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                    random_run(20);
                join
            end
            if (ph == 3) idle_on = 1'b0;
            random_run(290);
            drain();
        end

        $display("Sent %0d frames, %0d checked, across knee, clamp, bypass and ramp cases.",
                 frames_sent, sb.checked);
        $display("Settings included knee above ceiling, zero knee and unit mix steps.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Timeout");
        $display("Test completed with failures");
        $finish;
    end
endmodule
